>>> rtl/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// The antecedent implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The antecedent implies the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/ipv6d_pkg.sv
// Types, constants and helper functions of the IPv6 stream deframer.
package ipv6d_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int HDR_BYTES = 40;
   localparam int KEY_BYTES = 4;
   localparam int FLUSH_BYTES = HDR_BYTES + KEY_BYTES;
   localparam int HDR_ADDR_BITS = $clog2(HDR_BYTES);
   localparam int HDR_COUNT_BITS = 6;
   localparam int FLUSH_CNT_BITS = $clog2(FLUSH_BYTES);
   localparam int PLEN_BITS = 16;
   localparam logic [PLEN_BITS:0] PLEN_LIMIT = (PLEN_BITS + 1)'(MAX_FRAME_BYTES - 4 - HDR_BYTES);

   localparam logic [7:0] VER_MASK = 8'hF0;
   localparam logic [7:0] VER_CODE = 8'h60;

   localparam int VER_POS = 0;
   localparam int PLEN_HI_POS = 4;
   localparam int PLEN_LO_POS = 5;
   localparam int SRC_PFX_POS = 8;
   localparam int DST_PFX_POS = 24;
   localparam int PFX_BYTES = 6;
   localparam int PFX_IDX_BITS = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int KEY_BITS = 32;
   localparam int PREFIX_BITS = 48;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS = 48;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_KEY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ADDRESS_PREFIX = 1'd1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      logic       is_flush;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   function automatic logic [7:0] key_byte(input logic [KEY_BITS-1:0] key,
                                           input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = key[31:24];
         2'd1: b = key[23:16];
         2'd2: b = key[15:8];
         2'd3: b = key[7:0];
         default: b = '0;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] prefix_byte(input logic [PREFIX_BITS-1:0] pfx,
                                              input logic [PFX_IDX_BITS-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = pfx[47:40];
         3'd1: b = pfx[39:32];
         3'd2: b = pfx[31:24];
         3'd3: b = pfx[23:16];
         3'd4: b = pfx[15:8];
         3'd5: b = pfx[7:0];
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/ipv6_stream_deframer.sv
// Top level of the IPv6 stream deframer: configuration registers and the front, queue and emitter.
//
//   Channel  Direction  Payload              Handshake
//   req_     in         req_type             req_valid / req_ready
//   rsp_     out        rsp_type             rsp_valid / rsp_ready
//   csr_     in         csr_index, csr_data  csr_valid / csr_ready (always ready)
//
// Payload bytes and header bytes are taken at one transaction per cycle when not stalled.
// A header that passes is flushed by the emitter: it first takes the flush command from the
// four-entry queue, then emits the key and then the header bytes, read from a 40-byte RAM.
// While that flush runs, the input stalls only on a full queue or when it would collect a new header.
// Reset is synchronous and clears all control state; the header RAM is not cleared.
// A full queue or a stalled output register holds the input back.
module ipv6_stream_deframer import ipv6d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic [KEY_BITS-1:0]      frame_key_ff, frame_key_in;
   logic [PREFIX_BITS-1:0]   address_prefix_ff, address_prefix_in;
   logic                     flush_done;
   logic                     q_full;
   logic                     q_empty;
   logic                     push;
   logic                     pop;
   cmd_type                  push_data;
   cmd_type                  q_head;
   logic                     ram_we;
   logic [HDR_ADDR_BITS-1:0] ram_waddr;
   logic [HDR_ADDR_BITS-1:0] ram_raddr;
   logic [7:0]               ram_wdata;
   logic [7:0]               ram_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_key_in      = frame_key_ff;
      address_prefix_in = address_prefix_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_KEY:      frame_key_in      = csr_data[KEY_BITS-1:0];
            CSR_ADDRESS_PREFIX: address_prefix_in = csr_data[PREFIX_BITS-1:0];
            default: begin
               frame_key_in      = frame_key_ff;
               address_prefix_in = address_prefix_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_key_ff      <= '0;
         address_prefix_ff <= '0;
      end else begin
         frame_key_ff      <= frame_key_in;
         address_prefix_ff <= address_prefix_in;
      end
   end

   ipv6d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .address_prefix (address_prefix_ff),
      .flush_done     (flush_done),
      .q_full         (q_full),
      .push           (push),
      .push_data      (push_data),
      .ram_we         (ram_we),
      .ram_addr       (ram_waddr),
      .ram_wdata      (ram_wdata)
   );

   ipv6d_ram #(
      .WIDTH (8),
      .DEPTH (HDR_BYTES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ipv6d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ipv6d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .frame_key  (frame_key_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .pop        (pop),
      .ram_addr   (ram_raddr),
      .ram_rdata  (ram_rdata),
      .flush_done (flush_done),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/ipv6d_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ipv6d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ipv6d_front.sv
// Front end: accepts stream transactions, collects and checks headers, forwards payload.
`include "assert_macros.svh"
module ipv6d_front import ipv6d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   input  logic [PREFIX_BITS-1:0]   address_prefix,
   input  logic                     flush_done,
   input  logic                     q_full,
   output logic                     push,
   output cmd_type                  push_data,
   output logic                     ram_we,
   output logic [HDR_ADDR_BITS-1:0] ram_addr,
   output logic [7:0]               ram_wdata
);

   logic [HDR_COUNT_BITS-1:0] hdr_count_ff, hdr_count_in;
   logic [PLEN_BITS-1:0]      payload_left_ff, payload_left_in;
   logic                      passing_ff, passing_in;
   logic                      busy_ff, busy_in;
   logic                      chk_ok_ff, chk_ok_in;
   logic [7:0]                plen_hi_ff, plen_hi_in;
   logic [7:0]                plen_lo_ff, plen_lo_in;
   logic                      accept;
   logic [PLEN_BITS-1:0]      left_dec;
   logic [PLEN_BITS-1:0]      plen;
   logic [7:0]                byte_in;

   assign req_ready = !q_full && (passing_ff || !busy_ff);
   assign accept    = req_valid && req_ready;
   assign byte_in   = req_data.stream_byte;
   assign left_dec  = payload_left_ff - PLEN_BITS'(1);
   assign plen      = {plen_hi_ff, plen_lo_ff};

   always_comb begin
      hdr_count_in    = hdr_count_ff;
      payload_left_in = payload_left_ff;
      passing_in      = passing_ff;
      busy_in         = flush_done ? 1'b0 : busy_ff;
      chk_ok_in       = chk_ok_ff;
      plen_hi_in      = plen_hi_ff;
      plen_lo_in      = plen_lo_ff;
      push            = 1'b0;
      push_data       = '0;
      ram_we          = 1'b0;
      ram_addr        = HDR_ADDR_BITS'(hdr_count_ff);
      ram_wdata       = byte_in;
      if (accept) begin
         if (req_data.kind == KIND_CLOSE) begin
            hdr_count_in    = '0;
            payload_left_in = '0;
            passing_in      = 1'b0;
         end else if (passing_ff) begin
            push            = 1'b1;
            push_data.data  = byte_in;
            push_data.last  = (left_dec == '0);
            payload_left_in = left_dec;
            if (left_dec == '0) begin
               passing_in   = 1'b0;
               hdr_count_in = '0;
            end
         end else begin
            ram_we       = 1'b1;
            hdr_count_in = hdr_count_ff + HDR_COUNT_BITS'(1);
            if (hdr_count_ff == HDR_COUNT_BITS'(VER_POS)) begin
               chk_ok_in = ((byte_in & VER_MASK) == VER_CODE);
            end
            if (hdr_count_ff == HDR_COUNT_BITS'(PLEN_HI_POS)) begin
               plen_hi_in = byte_in;
            end
            if (hdr_count_ff == HDR_COUNT_BITS'(PLEN_LO_POS)) begin
               plen_lo_in = byte_in;
            end
            if (hdr_count_ff >= HDR_COUNT_BITS'(SRC_PFX_POS) &&
                hdr_count_ff < HDR_COUNT_BITS'(SRC_PFX_POS + PFX_BYTES)) begin
               chk_ok_in = chk_ok_ff && (byte_in == prefix_byte(address_prefix,
                  PFX_IDX_BITS'(hdr_count_ff - HDR_COUNT_BITS'(SRC_PFX_POS))));
            end
            if (hdr_count_ff >= HDR_COUNT_BITS'(DST_PFX_POS) &&
                hdr_count_ff < HDR_COUNT_BITS'(DST_PFX_POS + PFX_BYTES)) begin
               chk_ok_in = chk_ok_ff && (byte_in == prefix_byte(address_prefix,
                  PFX_IDX_BITS'(hdr_count_ff - HDR_COUNT_BITS'(DST_PFX_POS))));
            end
            if (hdr_count_ff == HDR_COUNT_BITS'(HDR_BYTES - 1)) begin
               hdr_count_in = '0;
               if (chk_ok_ff && plen != '0 && {1'b0, plen} <= PLEN_LIMIT) begin
                  push               = 1'b1;
                  push_data.is_flush = 1'b1;
                  passing_in         = 1'b1;
                  payload_left_in    = plen;
                  busy_in            = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff    <= '0;
         payload_left_ff <= '0;
         passing_ff      <= 1'b0;
         busy_ff         <= 1'b0;
      end else begin
         hdr_count_ff    <= hdr_count_in;
         payload_left_ff <= payload_left_in;
         passing_ff      <= passing_in;
         busy_ff         <= busy_in;
      end
      chk_ok_ff  <= chk_ok_in;
      plen_hi_ff <= plen_hi_in;
      plen_lo_ff <= plen_lo_in;
   end

   `ASSERT_ALWAYS(a_no_write_while_flushing, clock, reset, !(ram_we && busy_ff))
   `ASSERT_IMPLIES(a_passing_has_bytes_left, clock, reset, passing_ff,
      payload_left_ff != '0)

endmodule

>>> rtl/ipv6d_queue.sv
// Short command queue between the front end and the emitter.
`include "assert_macros.svh"
module ipv6d_queue import ipv6d_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type                     entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && full))
   `ASSERT_ALWAYS(a_no_pop_when_empty, clock, reset, !(pop && empty))

endmodule

>>> rtl/ipv6d_back.sv
// Emitter: turns queued commands into output bytes, flushing key and header on demand.
`include "assert_macros.svh"
module ipv6d_back import ipv6d_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [KEY_BITS-1:0]      frame_key,
   input  logic                     q_empty,
   input  cmd_type                  q_head,
   output logic                     pop,
   output logic [HDR_ADDR_BITS-1:0] ram_addr,
   input  logic [7:0]               ram_rdata,
   output logic                     flush_done,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   typedef enum logic [1:0] {
      BACK_IDLE  = 2'b01,
      BACK_FLUSH = 2'b10
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic [FLUSH_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_data_ff, rsp_data_in;
   logic                      out_free;
   logic                      load;
   rsp_type                   load_data;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pop        = 1'b0;
      load       = 1'b0;
      load_data  = '0;
      flush_done = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (q_head.is_flush) begin
                  state_in = BACK_FLUSH;
                  cnt_in   = '0;
               end else begin
                  load                 = 1'b1;
                  load_data.out_byte   = q_head.data;
                  load_data.frame_last = q_head.last;
               end
            end
         end
         BACK_FLUSH: begin
            if (out_free) begin
               load = 1'b1;
               if (cnt_ff < FLUSH_CNT_BITS'(KEY_BYTES)) begin
                  load_data.out_byte = key_byte(frame_key, cnt_ff[1:0]);
               end else begin
                  load_data.out_byte = ram_rdata;
               end
               if (cnt_ff == FLUSH_CNT_BITS'(FLUSH_BYTES - 1)) begin
                  state_in   = BACK_IDLE;
                  cnt_in     = '0;
                  flush_done = 1'b1;
               end else begin
                  cnt_in = cnt_ff + FLUSH_CNT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // The read address follows the next count, so the registered data matches the current one.
   assign ram_addr = (cnt_in >= FLUSH_CNT_BITS'(KEY_BYTES)) ?
                     HDR_ADDR_BITS'(cnt_in - FLUSH_CNT_BITS'(KEY_BYTES)) : '0;

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load ? load_data : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLIES(a_flush_count_in_range, clock, reset, state_ff == BACK_FLUSH,
      cnt_ff <= FLUSH_CNT_BITS'(FLUSH_BYTES - 1))
   `ASSERT_NEXT(a_done_returns_idle, clock, reset, flush_done, state_ff == BACK_IDLE)

endmodule

>>> tb/sv/ipv6d_checker.sv
// Checker for the IPv6 stream deframer: predicts the emitted frame bytes and compares them.
module ipv6d_checker import ipv6d_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_type                   rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending,
   output int                        frames_out,
   output int                        headers_rejected,
   output int                        rsp_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]                hdr_bytes [HDR_BYTES];
   logic [HDR_COUNT_BITS-1:0] hdr_fill;
   logic [PLEN_BITS-1:0]      bytes_to_pass;
   logic                      in_payload;
   logic [KEY_BITS-1:0]       key_reg;
   logic [PREFIX_BITS-1:0]    prefix_reg;
   rsp_type                   frame_bytes_due [$];

   function automatic bit prefix_matches(input int base);
      for (int i = 0; i < PFX_BYTES; i++) begin
         if (hdr_bytes[base + i] != prefix_reg[PREFIX_BITS - 1 - 8 * i -: 8])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic absorb_request(input req_type item);
      logic [PLEN_BITS-1:0] plen;
      bit                   accepted;
      rsp_type              due;
      if (item.kind == KIND_CLOSE) begin
         hdr_fill = '0;
         bytes_to_pass = '0;
         in_payload = 1'b0;
         return;
      end
      if (in_payload) begin
         bytes_to_pass = bytes_to_pass - 1'b1;
         due.out_byte = item.stream_byte;
         due.frame_last = (bytes_to_pass == '0);
         frame_bytes_due.push_back(due);
         if (bytes_to_pass == '0) begin
            in_payload = 1'b0;
            hdr_fill = '0;
         end
         return;
      end
      if (hdr_fill >= HDR_BYTES)
         hdr_fill = '0;
      hdr_bytes[hdr_fill] = item.stream_byte;
      hdr_fill = hdr_fill + 1'b1;
      if (hdr_fill < HDR_BYTES)
         return;
      hdr_fill = '0;
      plen = {hdr_bytes[PLEN_HI_POS], hdr_bytes[PLEN_LO_POS]};
      accepted = ((hdr_bytes[VER_POS] & VER_MASK) == VER_CODE) && (plen != '0)
         && prefix_matches(DST_PFX_POS) && prefix_matches(SRC_PFX_POS)
         && (int'(plen) + HDR_BYTES <= MAX_FRAME_BYTES - KEY_BYTES);
      if (!accepted) begin
         headers_rejected++;
         return;
      end
      for (int i = 0; i < KEY_BYTES; i++) begin
         due.out_byte = key_reg[KEY_BITS - 1 - 8 * i -: 8];
         due.frame_last = 1'b0;
         frame_bytes_due.push_back(due);
      end
      for (int i = 0; i < HDR_BYTES; i++) begin
         due.out_byte = hdr_bytes[i];
         due.frame_last = 1'b0;
         frame_bytes_due.push_back(due);
      end
      bytes_to_pass = plen;
      in_payload = 1'b1;
      frames_out++;
   endtask

   // Handshake signals only change at the rising edge, so they are sampled at the falling edge.
   always @(negedge clock) begin
      rsp_type want;
      if (reset) begin
         hdr_fill = '0;
         bytes_to_pass = '0;
         in_payload = 1'b0;
         key_reg = '0;
         prefix_reg = '0;
         frame_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_KEY: key_reg = csr_data[KEY_BITS-1:0];
               CSR_ADDRESS_PREFIX: prefix_reg = csr_data[PREFIX_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            rsp_checked++;
            if (frame_bytes_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected response, expected none, actual out_byte %02h frame_last %0b",
                        $time, rsp_data.out_byte, rsp_data.frame_last);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  fail_count++;
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  fail_count++;
                  $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                           $time, want.frame_last, rsp_data.frame_last);
               end
            end
         end
         if (req_valid && req_ready)
            absorb_request(req_data);
      end
      pending = frame_bytes_due.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top for the IPv6 stream deframer: clock, reset, stimulus, response stalls and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ipv6d_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 100;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int MAX_PLEN = MAX_FRAME_BYTES - KEY_BYTES - HDR_BYTES;

   typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_BLOCKS} sink_mode_type;
   typedef enum logic [2:0] {
      FAULT_VERSION, FAULT_EMPTY, FAULT_SOURCE, FAULT_DEST, FAULT_SIZE
   } header_fault_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   int fail_count;
   int pending;
   int frames_out;
   int headers_rejected;
   int rsp_checked;

   int                     cycle_count = 0;
   int                     items_sent = 0;
   int                     settings_used = 0;
   int                     burst_left = 0;
   logic [PREFIX_BITS-1:0] cur_prefix;
   logic [7:0]             frame_q [$];

   sink_mode_type sink_mode = SINK_OPEN;
   int            mode_timer = 0;
   int            beat = 0;
   int            hold = 0;

   ipv6_stream_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ipv6d_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .frames_out       (frames_out),
      .headers_rejected (headers_rejected),
      .rsp_checked      (rsp_checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending);
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver switches at random moments to a randomly chosen stall behaviour.
   always @(posedge clock) begin
      beat <= beat + 1;
      if (mode_timer == 0) begin
         mode_timer <= $urandom_range(50, 300);
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
      end else begin
         mode_timer <= mode_timer - 1;
      end
      case (sink_mode)
         SINK_OPEN: rsp_ready <= 1'b1;
         SINK_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
         SINK_PERIODIC: rsp_ready <= ((beat % 7) >= 2);
         default: begin
            if (hold != 0) begin
               hold <= hold - 1;
               rsp_ready <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
               hold <= $urandom_range(4, 12);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   task automatic send_item(input logic item_kind, input logic [7:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{kind: item_kind, stream_byte: value};
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic send_close();
      send_item(KIND_CLOSE, 8'($urandom));
   endtask

   task automatic send_queued();
      while (frame_q.size() != 0)
         send_item(KIND_DATA, frame_q.pop_front());
   endtask

   task automatic queue_header(input logic [3:0] version, input logic [15:0] plen,
                               input logic [47:0] src_pfx, input logic [47:0] dst_pfx);
      frame_q.push_back({version, 4'($urandom)});
      repeat (3) frame_q.push_back(8'($urandom));
      frame_q.push_back(plen[15:8]);
      frame_q.push_back(plen[7:0]);
      repeat (2) frame_q.push_back(8'($urandom));
      for (int i = 0; i < PFX_BYTES; i++)
         frame_q.push_back(src_pfx[47 - 8 * i -: 8]);
      repeat (10) frame_q.push_back(8'($urandom));
      for (int i = 0; i < PFX_BYTES; i++)
         frame_q.push_back(dst_pfx[47 - 8 * i -: 8]);
      repeat (10) frame_q.push_back(8'($urandom));
   endtask

   task automatic queue_payload(input int count);
      repeat (count) frame_q.push_back(8'($urandom));
   endtask

   task automatic good_packet(input int plen);
      queue_header(4'h6, 16'(plen), cur_prefix, cur_prefix);
      queue_payload(plen);
      send_queued();
   endtask

   task automatic bad_header(input header_fault_type fault);
      logic [3:0]  version;
      logic [15:0] plen;
      logic [47:0] src;
      logic [47:0] dst;
      version = 4'h6;
      plen = 16'($urandom_range(1, 40));
      src = cur_prefix;
      dst = cur_prefix;
      case (fault)
         FAULT_VERSION: version = 4'h6 ^ 4'($urandom_range(1, 15));
         FAULT_EMPTY: plen = '0;
         FAULT_SOURCE: src = src ^ (48'd1 << $urandom_range(0, 47));
         FAULT_DEST: dst = dst ^ (48'd1 << $urandom_range(0, 47));
         default: plen = 16'($urandom_range(MAX_PLEN + 1, 16'hFFFF));
      endcase
      queue_header(version, plen, src, dst);
      send_queued();
   endtask

   function automatic int random_plen();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
   endfunction

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [KEY_BITS-1:0] key, input logic [PREFIX_BITS-1:0] prefix);
      write_register(CSR_FRAME_KEY, {16'($urandom), key});
      write_register(CSR_ADDRESS_PREFIX, prefix);
      cur_prefix = prefix;
      settings_used++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      int stop_at;
      int pick;
      int plen;
      stop_at = items_sent + ITEMS_PER_PHASE;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            good_packet(random_plen());
         end else if (pick < 80) begin
            bad_header(header_fault_type'($urandom_range(0, 4)));
         end else if (pick < 88) begin
            plen = random_plen();
            queue_header(4'h6, 16'(plen), cur_prefix, cur_prefix);
            queue_payload(plen);
            repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            send_queued();
            send_close();
         end else if (pick < 94) begin
            good_packet(random_plen());
            send_close();
         end else begin
            repeat ($urandom_range(1, 30)) send_item(KIND_DATA, 8'($urandom));
            send_close();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      configure(32'hFFFF_FFFF, 48'h0);
      send_close();
      queue_header(4'h6, 16'd1, cur_prefix, cur_prefix);
      frame_q.push_back(8'h00);
      send_queued();
      queue_header(4'h5, 16'd4, cur_prefix, cur_prefix);
      queue_header(4'h6, 16'd0, cur_prefix, cur_prefix);
      queue_header(4'h6, 16'(MAX_PLEN + 1), cur_prefix, cur_prefix);
      send_queued();
      queue_header(4'h6, 16'(MAX_PLEN), cur_prefix, cur_prefix);
      queue_payload(4);
      send_queued();
      send_close();
      queue_header(4'h6, 16'd3, cur_prefix, cur_prefix);
      repeat (23) void'(frame_q.pop_back());
      send_queued();
      send_close();
      good_packet(2);
      send_close();
      drain();

      configure(32'h0, 48'hFFFF_FFFF_FFFF);
      random_phase();
      drain();
      configure($urandom, {16'($urandom), 32'($urandom)});
      random_phase();
      drain();
      configure($urandom, {16'($urandom), 32'($urandom)});
      random_phase();
      drain();

      $display("Sent %0d request transactions under %0d register settings: %0d frames emitted,",
               items_sent, settings_used, frames_out);
      $display("%0d headers rejected and %0d response transactions checked.",
               headers_rejected, rsp_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ipv6d_pkg.sv
rtl/ipv6d_ram.sv
rtl/ipv6d_front.sv
rtl/ipv6d_queue.sv
rtl/ipv6d_back.sv
rtl/ipv6_stream_deframer.sv
tb/sv/ipv6d_checker.sv
tb/sv/tb_top.sv
